// ===== rtl/fee_pkg.sv =====
// Package for the filename escape encoder: shared types, character codes
// and small byte classification functions. No dependencies.
`default_nettype none

package fee_pkg;

    // Buffer size ceiling; larger buffer_length values saturate to this.
    localparam int          MAX_BUFFER  = 1024;
    localparam logic [10:0] MAX_BUF_LEN = 11'(MAX_BUFFER);

    // Operation queue between front and back.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    // Character codes
    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BANG      = 8'h21;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_ESC_LIMIT = 8'h27;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_DOT       = 8'h2E;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_QUERY     = 8'h3F;
    localparam logic [7:0] CH_AT        = 8'h40;
    localparam logic [7:0] CH_UA        = 8'h41;
    localparam logic [7:0] CH_UF        = 8'h46;
    localparam logic [7:0] CH_BSLASH    = 8'h5C;
    localparam logic [7:0] CH_LA        = 8'h61;
    localparam logic [7:0] CH_LF        = 8'h66;
    localparam logic [7:0] CH_DEL       = 8'h7F;
    localparam logic [7:0] CH_NBSP      = 8'hA0;
    localparam logic [7:0] HI_MASK      = 8'hF0;
    localparam logic [7:0] LO_MASK      = 8'h0F;

    // Register indexes on the configuration port
    typedef enum logic [1:0] {
        CFG_SUFFIX_EN     = 2'd0,
        CFG_DEFAULT_FTYPE = 2'd1,
        CFG_BUF_LEN       = 2'd2
    } t_cfg_idx;

    // type_source codes
    localparam logic [1:0] SRC_SUFFIX  = 2'd0;
    localparam logic [1:0] SRC_DEFAULT = 2'd1;
    localparam logic [1:0] SRC_LOOKUP  = 2'd2;

    typedef struct packed {
        logic        suffix_en;
        logic [11:0] default_ftype;
        logic [10:0] buf_len;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_BYTE       = 2'd0,   // translate one source byte
        OP_BYTE_END   = 2'd1,   // translate one byte, then close the name
        OP_SUFFIX_END = 2'd2    // close the name with a type from the suffix
    } t_opkind;

    typedef struct packed {
        t_opkind     kind;
        logic [7:0]  data;
        logic [11:0] ftype;
    } t_op;

    typedef enum logic [0:0] {
        F_TAKE  = 1'b0,
        F_FLUSH = 1'b1
    } t_fstate;

    typedef enum logic [1:0] {
        B_FIRST = 2'd0,
        B_HI    = 2'd1,
        B_LO    = 2'd2,
        B_END   = 2'd3
    } t_bstep;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            v = c - CH_ZERO;
        end else if (c >= CH_LA && c <= CH_LF) begin
            v = c - CH_LA + 8'd10;
        end else if (c >= CH_UA && c <= CH_UF) begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        return (v < 4'd10) ? CH_ZERO + {4'h0, v} : CH_UA + {4'h0, v} - 8'd10;
    endfunction

    // True where a byte goes out as '?' plus two hex digits
    function automatic logic needs_escape(input logic [7:0] c);
        return (c != CH_SPACE) && (c != CH_BANG) &&
               ((c < CH_ESC_LIMIT) || (c == CH_SLASH) || (c == CH_COLON) ||
                (c == CH_QUERY) || (c == CH_AT) || (c == CH_BSLASH) ||
                (c == CH_DEL) || (c == CH_NBSP));
    endfunction

    // Single byte substitution for bytes that are not escaped
    function automatic logic [7:0] plain_xlate(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c == CH_DOT) begin
            r = CH_SLASH;
        end else if (c == CH_SPACE) begin
            r = CH_NBSP;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fee_fifo.sv =====
// Operation queue between front and back of the filename escape encoder.
// Depends on fee_pkg (t_op, FIFO_DEPTH).
`default_nettype none

module fee_fifo (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_push,
    input  wire fee_pkg::t_op i_din,
    output logic              o_full,
    input  wire logic         i_pop,
    output fee_pkg::t_op      o_dout,
    output logic              o_nempty
);
    import fee_pkg::*;

    t_op                r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wptr, n_wptr;
    logic [FIFO_AW-1:0] r_rptr, n_rptr;
    logic [FIFO_AW:0]   r_cnt,  n_cnt;
    logic               w_push, w_pop;

    assign o_full   = (r_cnt == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_nempty = (r_cnt != '0);
    assign o_dout   = r_mem[r_rptr];
    assign w_push   = i_push && !o_full;
    assign w_pop    = i_pop && o_nempty;

    always_comb begin
        n_wptr = w_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr = w_pop  ? r_rptr + 1'b1 : r_rptr;
        n_cnt  = r_cnt;
        if (w_push && !w_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!w_push && w_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_din;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fee_front.sv =====
// Front end of the filename escape encoder: takes source bytes, holds a
// possible ",xyz" suffix and turns bytes into queue operations. Uses fee_pkg.
`default_nettype none

module fee_front (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_valid,
    output logic         o_ready,
    input  wire logic [7:0] i_name_byte,
    input  wire logic    i_last_byte,
    input  wire logic    i_suffix_en,
    output logic         o_push,
    output fee_pkg::t_op o_op,
    input  wire logic    i_full
);
    import fee_pkg::*;

    t_fstate    r_state, n_state;
    logic [7:0] r_held [3];
    logic [7:0] n_held [3];
    logic [1:0] r_hcnt, n_hcnt;
    logic [1:0] r_fidx, n_fidx;
    logic [7:0] r_cur, n_cur;
    logic       r_cur_last, n_cur_last;
    logic       w_hex;

    assign w_hex = is_hex(i_name_byte);

    always_comb begin
        n_state    = r_state;
        n_held     = r_held;
        n_hcnt     = r_hcnt;
        n_fidx     = r_fidx;
        n_cur      = r_cur;
        n_cur_last = r_cur_last;
        o_ready    = 1'b0;
        o_push     = 1'b0;
        o_op       = '{kind: OP_BYTE, data: CH_NUL, ftype: 12'h000};
        unique case (r_state)
            F_TAKE: begin
                o_ready = !i_full;
                if (i_valid && !i_full) begin
                    priority if (r_hcnt != 2'd0 && r_hcnt != 2'd3 && i_suffix_en &&
                                 w_hex && !i_last_byte) begin
                        n_held[r_hcnt] = i_name_byte;
                        n_hcnt         = r_hcnt + 2'd1;
                    end else if (r_hcnt == 2'd3 && i_suffix_en && w_hex &&
                                 i_last_byte) begin
                        o_push = 1'b1;
                        o_op   = '{kind: OP_SUFFIX_END, data: CH_NUL,
                                   ftype: {hex_val(r_held[1]), hex_val(r_held[2]),
                                           hex_val(i_name_byte)}};
                        n_hcnt = 2'd0;
                    end else if (r_hcnt == 2'd0) begin
                        if (i_suffix_en && i_name_byte == CH_COMMA && !i_last_byte) begin
                            n_held[0] = i_name_byte;
                            n_hcnt    = 2'd1;
                        end else begin
                            o_push = 1'b1;
                            o_op   = '{kind: i_last_byte ? OP_BYTE_END : OP_BYTE,
                                       data: i_name_byte, ftype: 12'h000};
                        end
                    end else begin
                        // held bytes go out as text first
                        n_state    = F_FLUSH;
                        n_fidx     = 2'd0;
                        n_cur      = i_name_byte;
                        n_cur_last = i_last_byte;
                    end
                end
            end
            F_FLUSH: begin
                if (r_fidx != r_hcnt) begin
                    o_push = !i_full;
                    o_op   = '{kind: OP_BYTE, data: r_held[r_fidx], ftype: 12'h000};
                    if (!i_full) begin
                        n_fidx = r_fidx + 2'd1;
                    end
                end else if (i_suffix_en && r_cur == CH_COMMA && !r_cur_last) begin
                    n_held[0] = r_cur;
                    n_hcnt    = 2'd1;
                    n_state   = F_TAKE;
                end else begin
                    o_push = !i_full;
                    o_op   = '{kind: r_cur_last ? OP_BYTE_END : OP_BYTE,
                               data: r_cur, ftype: 12'h000};
                    if (!i_full) begin
                        n_hcnt  = 2'd0;
                        n_state = F_TAKE;
                    end
                end
            end
            default: begin
                n_state = F_TAKE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_TAKE;
            r_hcnt  <= 2'd0;
            r_fidx  <= 2'd0;
        end else begin
            r_state <= n_state;
            r_hcnt  <= n_hcnt;
            r_fidx  <= n_fidx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held     <= n_held;
        r_cur      <= n_cur;
        r_cur_last <= n_cur_last;
    end

endmodule

`default_nettype wire

// ===== rtl/fee_back.sv =====
// Back end of the filename escape encoder: runs queued operations, checks
// buffer room, emits translated bytes and the closing NUL. Uses fee_pkg.
`default_nettype none

module fee_back (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_head_valid,
    input  wire fee_pkg::t_op i_head,
    output logic         o_pop,
    input  wire fee_pkg::t_cfg i_cfg,
    output logic         o_valid,
    input  wire logic    i_ready,
    output logic [7:0]   o_out_byte,
    output logic         o_out_last,
    output logic [10:0]  o_out_length,
    output logic [11:0]  o_file_type,
    output logic [1:0]   o_type_source,
    output logic         o_overflow
);
    import fee_pkg::*;

    t_bstep      r_step, n_step;
    logic [10:0] r_written, n_written;
    logic        r_dot, n_dot;
    logic        r_ovf, n_ovf;
    logic        r_sfx, n_sfx;
    logic [11:0] r_ftype, n_ftype;

    logic        r_ovalid;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic [10:0] r_olen;
    logic [11:0] r_oftype;
    logic [1:0]  r_osrc;
    logic        r_oovf;

    logic        w_slot, w_room, w_esc, w_end;
    logic [10:0] w_buflen;
    logic        e_emit, e_last, e_ovf;
    logic [7:0]  e_byte;
    logic [10:0] e_len;
    logic [11:0] e_ftype;
    logic [1:0]  e_src;

    assign w_slot   = !r_ovalid || i_ready;
    assign w_buflen = (i_cfg.buf_len > MAX_BUF_LEN) ? MAX_BUF_LEN : i_cfg.buf_len;
    assign w_room   = ({1'b0, r_written} + 12'd3) < {1'b0, w_buflen};
    assign w_esc    = needs_escape(i_head.data);
    assign w_end    = (i_head.kind == OP_BYTE_END);

    always_comb begin
        n_step    = r_step;
        n_written = r_written;
        n_dot     = r_dot;
        n_ovf     = r_ovf;
        n_sfx     = r_sfx;
        n_ftype   = r_ftype;
        o_pop     = 1'b0;
        e_emit    = 1'b0;
        e_byte    = CH_NUL;
        e_last    = 1'b0;
        e_len     = 11'd0;
        e_ftype   = 12'h000;
        e_src     = SRC_SUFFIX;
        e_ovf     = 1'b0;
        unique case (r_step)
            B_FIRST: begin
                if (i_head_valid) begin
                    if (i_head.kind == OP_SUFFIX_END) begin
                        if (!r_ovf && w_room) begin
                            n_sfx   = 1'b1;
                            n_ftype = i_head.ftype;
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_step = B_END;
                    end else if (r_ovf || !w_room) begin
                        // byte dropped, name has overflowed
                        n_ovf = 1'b1;
                        if (w_end) begin
                            n_step = B_END;
                        end else begin
                            o_pop = 1'b1;
                        end
                    end else if (w_slot) begin
                        e_emit    = 1'b1;
                        e_byte    = w_esc ? CH_QUERY : plain_xlate(i_head.data);
                        n_written = r_written + (w_esc ? 11'd3 : 11'd1);
                        n_dot     = r_dot || (i_head.data == CH_DOT);
                        if (w_esc) begin
                            n_step = B_HI;
                        end else if (w_end) begin
                            n_step = B_END;
                        end else begin
                            o_pop = 1'b1;
                        end
                    end
                end
            end
            B_HI: begin
                if (w_slot) begin
                    e_emit = 1'b1;
                    e_byte = nibble_char(4'((i_head.data & HI_MASK) >> 4));
                    n_step = B_LO;
                end
            end
            B_LO: begin
                if (w_slot) begin
                    e_emit = 1'b1;
                    e_byte = nibble_char(4'(i_head.data & LO_MASK));
                    if (w_end) begin
                        n_step = B_END;
                    end else begin
                        o_pop  = 1'b1;
                        n_step = B_FIRST;
                    end
                end
            end
            B_END: begin
                if (w_slot) begin
                    e_emit = 1'b1;
                    e_last = 1'b1;
                    if (r_ovf) begin
                        e_ovf = 1'b1;
                    end else begin
                        e_len = r_written + 11'd1;
                        if (r_sfx) begin
                            e_ftype = r_ftype;
                            e_src   = SRC_SUFFIX;
                        end else if (i_cfg.suffix_en && r_dot) begin
                            e_ftype = i_cfg.default_ftype;
                            e_src   = SRC_LOOKUP;
                        end else begin
                            e_ftype = i_cfg.default_ftype;
                            e_src   = SRC_DEFAULT;
                        end
                    end
                    o_pop     = 1'b1;
                    n_step    = B_FIRST;
                    n_written = 11'd0;
                    n_dot     = 1'b0;
                    n_ovf     = 1'b0;
                    n_sfx     = 1'b0;
                end
            end
            default: begin
                n_step = B_FIRST;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= B_FIRST;
            r_written <= 11'd0;
            r_dot     <= 1'b0;
            r_ovf     <= 1'b0;
            r_sfx     <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_step    <= n_step;
            r_written <= n_written;
            r_dot     <= n_dot;
            r_ovf     <= n_ovf;
            r_sfx     <= n_sfx;
            if (w_slot) begin
                r_ovalid <= e_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ftype <= n_ftype;
        if (e_emit) begin
            r_obyte  <= e_byte;
            r_olast  <= e_last;
            r_olen   <= e_len;
            r_oftype <= e_ftype;
            r_osrc   <= e_src;
            r_oovf   <= e_ovf;
        end
    end

    assign o_valid       = r_ovalid;
    assign o_out_byte    = r_obyte;
    assign o_out_last    = r_olast;
    assign o_out_length  = r_olen;
    assign o_file_type   = r_oftype;
    assign o_type_source = r_osrc;
    assign o_overflow    = r_oovf;

endmodule

`default_nettype wire

// ===== rtl/filename_escape_encoder_core.sv =====
// Filename escape encoder, top level: configuration registers, front end,
// operation queue and back end. Depends on fee_pkg, fee_front, fee_fifo, fee_back.
//
// Use: source filename bytes enter on the i_valid/o_ready channel, one byte
// per beat, i_last_byte set on the final byte. Translated bytes leave on the
// o_valid/i_ready channel, one byte per beat; the final beat of a name is a
// NUL with o_out_last set and carries length, file type, type source and the
// overflow flag. Configuration is written on i_cfg_valid/o_cfg_ready (index
// 0 suffix enable, 1 default type, 2 buffer length) while the block is idle.
// Throughput: the back end emits one beat per cycle while the receiver is
// ready; a plain byte takes one beat, an escaped byte three and the closing
// NUL one more. The front takes one byte per cycle while the queue has room;
// when held suffix bytes turn out to be plain text it stops taking input
// while it queues the held bytes, then the byte that broke the suffix. The
// back end's single output register sets the sustained rate.
// Reset (synchronous, active low) restores the register defaults and clears
// all per-name state; the queue comes up empty. When the receiver stalls the
// output register holds, the four-entry queue fills, then o_ready drops.
`default_nettype none

module filename_escape_encoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_name_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_out_byte,
    output logic             o_out_last,
    output logic [10:0]      o_out_length,
    output logic [11:0]      o_file_type,
    output logic [1:0]       o_type_source,
    output logic             o_overflow,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [11:0] i_cfg_data
);
    import fee_pkg::*;

    t_cfg r_cfg, n_cfg;
    logic w_push, w_full, w_pop, w_nempty;
    t_op  w_op, w_head;

    // Config writes are always taken; unknown index is ignored.
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SUFFIX_EN:     n_cfg.suffix_en     = i_cfg_data[0];
                CFG_DEFAULT_FTYPE: n_cfg.default_ftype = i_cfg_data;
                CFG_BUF_LEN:       n_cfg.buf_len       = i_cfg_data[10:0];
                default:           n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{suffix_en: 1'b1, default_ftype: 12'hFFF, buf_len: MAX_BUF_LEN};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front: suffix hold and byte classification
    fee_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_name_byte (i_name_byte),
        .i_last_byte (i_last_byte),
        .i_suffix_en (r_cfg.suffix_en),
        .o_push      (w_push),
        .o_op        (w_op),
        .i_full      (w_full)
    );

    // Queue decouples the two halves
    fee_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_din    (w_op),
        .o_full   (w_full),
        .i_pop    (w_pop),
        .o_dout   (w_head),
        .o_nempty (w_nempty)
    );

    // Back: room check, escaping, NUL and metadata
    fee_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_valid  (w_nempty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .i_cfg         (r_cfg),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_out_last    (o_out_last),
        .o_out_length  (o_out_length),
        .o_file_type   (o_file_type),
        .o_type_source (o_type_source),
        .o_overflow    (o_overflow)
    );

endmodule

`default_nettype wire

// ===== dv/filename_escape_encoder_core_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for filename_escape_encoder_core: a scoreboard class
// predicts every output beat from the accepted source bytes and checks them in
// order. Depends on fee_pkg and the filename_escape_encoder_core RTL.

module filename_escape_encoder_core_test;
    import fee_pkg::*;

    // Register index that the block must ignore
    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
    // Generous watchdog ceiling on the run length
    localparam int CYCLE_LIMIT = 300000;

    // One output beat as the block should present it
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [10:0] length;
        logic [11:0] ftype;
        logic [1:0]  src;
        logic        ovf;
    } t_beat;

    // Predicts the translated name beat by beat and checks the block against it
    class escaped_name_board;
        // register copies
        logic        suffix_on;
        logic [11:0] dflt_type;
        logic [10:0] buf_len;
        // per-name state
        logic [7:0]  held [3];
        int unsigned held_n;
        int unsigned written;
        bit          dot;
        bit          ovf;

        t_beat       pending_beats [$];
        string       digits;
        int unsigned errors;
        int unsigned beats_checked;
        int unsigned names;
        int unsigned overflowed;
        int unsigned typed;

        function new();
            digits    = "0123456789ABCDEF";
            suffix_on = 1'b1;
            dflt_type = 12'hFFF;
            buf_len   = 11'd1024;
            clear_name();
        endfunction

        function void clear_name();
            held[0] = '0;
            held[1] = '0;
            held[2] = '0;
            held_n  = 0;
            written = 0;
            dot     = 0;
            ovf     = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [11:0] val);
            case (idx)
                CFG_SUFFIX_EN:     suffix_on = val[0];
                CFG_DEFAULT_FTYPE: dflt_type = val;
                CFG_BUF_LEN:       buf_len   = val[10:0];
                default: ;
            endcase
        endfunction

        function int unsigned room();
            return (buf_len > MAX_BUF_LEN) ? MAX_BUF_LEN : buf_len;
        endfunction

        // -1 for anything that is not a hex digit
        function int digit_value(logic [7:0] c);
            if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
            if (c >= CH_LA && c <= CH_LF) return int'(c) - int'(CH_LA) + 10;
            if (c >= CH_UA && c <= CH_UF) return int'(c) - int'(CH_UA) + 10;
            return -1;
        endfunction

        function bit is_escaped(logic [7:0] c);
            return (c < CH_ESC_LIMIT && c != CH_BANG) || c == CH_SLASH ||
                   c == CH_COLON || c == CH_QUERY || c == CH_AT ||
                   c == CH_BSLASH || c == CH_DEL || c == CH_NBSP;
        endfunction

        function void emit(logic [7:0] b);
            t_beat x;
            x      = '0;
            x.data = b;
            pending_beats.push_back(x);
        endfunction

        // One source byte through the room test and the substitution rules
        function void translate(logic [7:0] c);
            if (ovf) return;
            if (written + 3 >= room()) begin
                ovf = 1;
                return;
            end
            if (c == CH_DOT) begin
                emit(CH_SLASH);
                dot = 1;
                written++;
            end else if (c == CH_SPACE) begin
                emit(CH_NBSP);
                written++;
            end else if (is_escaped(c)) begin
                emit(CH_QUERY);
                emit(digits[c[7:4]]);
                emit(digits[c[3:0]]);
                written += 3;
            end else begin
                emit(c);
                written++;
            end
        endfunction

        function void take_source_byte(logic [7:0] c, logic lst);
            t_beat       fin;
            bit          suffix_hit;
            bit          done;
            logic [11:0] ftype;
            int unsigned nh;

            suffix_hit = 0;
            done       = 0;
            ftype      = '0;
            if (!ovf) begin
                // suffix collection: comma then hex digits, the third on the last byte
                if (held_n > 0 && suffix_on && digit_value(c) >= 0) begin
                    if (held_n < 3 && !lst) begin
                        held[held_n] = c;
                        held_n++;
                        done = 1;
                    end else if (held_n == 3 && lst) begin
                        if (written + 3 < room()) begin
                            ftype = 12'((digit_value(held[1]) << 8) |
                                        (digit_value(held[2]) << 4) | digit_value(c));
                            suffix_hit = 1;
                        end else begin
                            ovf = 1;
                        end
                        held_n = 0;
                        done   = 1;
                    end
                end
                if (!done) begin
                    // what was held turns out to be plain text
                    nh     = held_n;
                    held_n = 0;
                    for (int k = 0; k < nh; k++) translate(held[k]);
                    if (suffix_on && c == CH_COMMA && !lst && !ovf) begin
                        held[0] = c;
                        held_n  = 1;
                    end else begin
                        translate(c);
                    end
                end
            end
            if (lst) begin
                fin      = '0;
                fin.last = 1'b1;
                names++;
                if (ovf) begin
                    fin.ovf = 1'b1;
                    overflowed++;
                end else begin
                    written++;
                    fin.length = written[10:0];
                    if (suffix_hit) begin
                        fin.ftype = ftype;
                        fin.src   = SRC_SUFFIX;
                        typed++;
                    end else begin
                        fin.ftype = dflt_type;
                        fin.src   = (suffix_on && dot) ? SRC_LOOKUP : SRC_DEFAULT;
                    end
                end
                pending_beats.push_back(fin);
                clear_name();
            end
        endfunction

        function void cmp_field(string what, logic [11:0] e, logic [11:0] a);
            if (a !== e) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: %s mismatch, expected %0h actual %0h", $time, what, e, a);
            end
        endfunction

        function void check_out_beat(logic [7:0] data, logic lst, logic [10:0] length,
                                     logic [11:0] ftype, logic [1:0] src, logic ovf_flag);
            t_beat e;
            if (pending_beats.size() == 0) begin
                errors++;
                if (errors <= 40)
                    $display("%0t: unexpected beat, expected none actual %0h", $time, data);
                return;
            end
            e = pending_beats.pop_front();
            beats_checked++;
            cmp_field("out_byte", 12'(e.data), 12'(data));
            cmp_field("out_last", 12'(e.last), 12'(lst));
            cmp_field("out_length", 12'(e.length), 12'(length));
            cmp_field("file_type", e.ftype, ftype);
            cmp_field("type_source", 12'(e.src), 12'(src));
            cmp_field("overflow", 12'(e.ovf), 12'(ovf_flag));
        endfunction
    endclass

    // Clock, reset and block inputs, all known from time zero
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_name_byte = '0;
    logic        i_last_byte = 1'b0;
    logic        i_ready     = 1'b1;
    logic        i_cfg_valid = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [11:0] i_cfg_data  = '0;

    logic        o_ready;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic [10:0] o_out_length;
    logic [11:0] o_file_type;
    logic [1:0]  o_type_source;
    logic        o_overflow;
    logic        o_cfg_ready;

    escaped_name_board board;
    logic [7:0]        name_q [$];
    int                items_sent    = 0;
    int                settings_used = 0;
    bit                tx_idle_on    = 1'b1;
    bit                rx_idle_on    = 1'b1;

    filename_escape_encoder_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_name_byte  (i_name_byte),
        .i_last_byte  (i_last_byte),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_byte   (o_out_byte),
        .o_out_last   (o_out_last),
        .o_out_length (o_out_length),
        .o_file_type  (o_file_type),
        .o_type_source(o_type_source),
        .o_overflow   (o_overflow),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    // 8 ns period
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Receiver: random stall bursts while enabled.
    // Ready only ever changes once per edge, so no two assignments collide.
    always begin
        @(posedge i_clk);
        if (rx_idle_on && $urandom_range(0, 5) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
            i_ready <= 1'b1;
        end
    end

    // Output monitor: values sampled here are the pre-edge ones the block saw
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready)
            board.check_out_beat(o_out_byte, o_out_last, o_out_length, o_file_type,
                                 o_type_source, o_overflow);
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d beats still expected", CYCLE_LIMIT,
                 board.pending_beats.size());
        $display("status: fail");
        $finish;
    end

    // One source beat; an optional idle burst comes first. Valid stays high
    // between back-to-back beats so it is never dropped and raised in one step.
    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_name_byte <= b;
        i_last_byte <= lst;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        board.take_source_byte(b, lst);
        items_sent++;
    endtask

    task automatic send_queued();
        for (int k = 0; k < name_q.size(); k++) send_byte(name_q[k], k == name_q.size() - 1);
    endtask

    task automatic send_text(input string s);
        name_q.delete();
        for (int k = 0; k < s.len(); k++) name_q.push_back(s[k]);
        send_queued();
    endtask

    // Drop valid, wait for every expected beat, then let the pipe empty out
    task automatic settle();
        i_valid <= 1'b0;
        while (board.pending_beats.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // Writes the spare index with junk first, then the three real registers
    task automatic apply_settings(input logic [11:0] sfx, input logic [11:0] dflt,
                                  input logic [11:0] blen);
        logic [1:0]  idx;
        logic [11:0] val;
        for (int k = 0; k < 4; k++) begin
            case (k)
                0: begin
                    idx = CFG_SPARE_IDX;
                    val = 12'($urandom);
                end
                1: begin
                    idx = CFG_SUFFIX_EN;
                    val = sfx;
                end
                2: begin
                    idx = CFG_DEFAULT_FTYPE;
                    val = dflt;
                end
                default: begin
                    idx = CFG_BUF_LEN;
                    val = blen;
                end
            endcase
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= val;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            board.write_reg(idx, val);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [7:0] pick_hex_digit();
        case ($urandom_range(0, 2))
            0:       return CH_ZERO + 8'($urandom_range(0, 9));
            1:       return CH_LA + 8'($urandom_range(0, 5));
            default: return CH_UA + 8'($urandom_range(0, 5));
        endcase
    endfunction

    function automatic logic [7:0] pick_escaped();
        case ($urandom_range(0, 7))
            0:       return CH_SLASH;
            1:       return CH_COLON;
            2:       return CH_QUERY;
            3:       return CH_AT;
            4:       return CH_BSLASH;
            5:       return CH_DEL;
            6:       return CH_NBSP;
            default: return 8'($urandom_range(0, 38));
        endcase
    endfunction

    function automatic logic [7:0] pick_text_byte();
        case ($urandom_range(0, 9))
            0:       return CH_DOT;
            1:       return CH_SPACE;
            2:       return CH_COMMA;
            3:       return pick_hex_digit();
            4:       return pick_escaped();
            5, 6:    return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(8'h41, 8'h7A));
        endcase
    endfunction

    // Well-formed ",xyz" names in just under half the cases; the rest plain text or broken suffixes
    task automatic build_random_name();
        int kind;
        kind = $urandom_range(0, 99);
        name_q.delete();
        repeat ($urandom_range(0, 6)) name_q.push_back(pick_text_byte());
        if (kind < 45) begin
            name_q.push_back(CH_COMMA);
            repeat (3) name_q.push_back(pick_hex_digit());
        end else if (kind < 75) begin
            repeat ($urandom_range(1, 5)) name_q.push_back(pick_text_byte());
        end else begin
            name_q.push_back(CH_COMMA);
            case ($urandom_range(0, 5))
                0: ;                                            // lone comma at the end
                1: name_q.push_back(pick_hex_digit());          // one digit short by two
                2: repeat (2) name_q.push_back(pick_hex_digit());
                3: repeat (4) name_q.push_back(pick_hex_digit());  // one digit too many
                4: begin                                        // digits cut off by text
                    repeat ($urandom_range(1, 2)) name_q.push_back(pick_hex_digit());
                    name_q.push_back($urandom_range(0, 1) ? CH_COMMA : pick_escaped());
                    repeat ($urandom_range(0, 3)) name_q.push_back(pick_hex_digit());
                end
                default: begin                                  // full suffix, then more
                    repeat (3) name_q.push_back(pick_hex_digit());
                    repeat ($urandom_range(1, 3)) name_q.push_back(pick_text_byte());
                end
            endcase
        end
    endtask

    initial begin
        int start_count;
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values first.
        // A lone NUL byte, then every substitution and the escape boundaries.
        send_byte(CH_NUL, 1'b1);
        send_text(". !\177\240/:?@\\\377&'");
        send_text(",1aF");
        settle();

        // suffix off: the suffix shape is ordinary text, default type
        apply_settings(12'h000, 12'h000, 12'd1024);
        send_text(",123");
        settle();

        // smallest usable buffer: one byte fits, two overflow, and a suffix
        // that fails the room test overflows too
        apply_settings(12'h001, 12'hFFF, 12'd4);
        send_text("a");
        send_text("ab");
        send_text("x,abc");
        settle();

        // buffer below four: everything overflows
        apply_settings(12'h001, 12'h5A5, 12'd3);
        send_text("a");

        // Random part: one register setting per phase, idling varied per phase,
        // the last phase runs with no idling at all
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_on = (ph != 1 && ph != 5);
            rx_idle_on = (ph != 3 && ph != 5);
            settle();
            case (ph)
                0: apply_settings(12'($urandom), 12'($urandom), 12'd1024);
                1: apply_settings(12'h000, 12'h000, 12'hFFF);      // saturates to the ceiling
                2: apply_settings(12'h001, 12'hFFF, 12'($urandom_range(4, 24)));
                3: apply_settings(12'hFFF, 12'($urandom), 12'($urandom_range(25, 60)));
                4: apply_settings(12'hFFE, 12'($urandom),
                                  $urandom_range(0, 1) ? 12'h800 : 12'($urandom_range(0, 3)));
                default: apply_settings(12'h001, 12'($urandom), 12'd1024);
            endcase
            if (ph == 1) begin
                // one long all-escaped name: overflows only if the saturated
                // buffer length is honoured
                name_q.delete();
                repeat (345) name_q.push_back(8'($urandom_range(0, 31)));
                send_queued();
            end
            start_count = items_sent;
            while (items_sent - start_count < ((ph == 4) ? 8 : 12)) begin
                build_random_name();
                send_queued();
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        $display("run covered %0d names, %0d source bytes, %0d register settings",
                 board.names, items_sent, settings_used);
        $display("%0d beats checked, %0d names overflowed, %0d typed by suffix",
                 board.beats_checked, board.overflowed, board.typed);
        if (board.errors == 0 && board.pending_beats.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
